@@ rtl/wifi_frame_header_parser_top_defines.svh @@
// ---------------------------------------------------------------------------
// Frame header parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset gated.
// ---------------------------------------------------------------------------
`ifndef WIFI_FRAME_HEADER_PARSER_TOP_DEFINES_SVH
`define WIFI_FRAME_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define WHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/whp_pkg.sv @@
// ---------------------------------------------------------------------------
// Frame header parser package
// Types, constants and helper functions shared by the parser modules.
// ---------------------------------------------------------------------------
package whp_pkg;

	localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
	localparam logic [31:0] EXT_BIT         = 32'h8000_0000;
	localparam logic [2:0]  NO_FIELD        = 3'd6;
	localparam logic [7:0]  TAG_DS          = 8'd3;
	localparam logic [7:0]  TAG_RSN         = 8'd48;
	localparam logic [7:0]  TAG_VENDOR      = 8'd221;

	localparam logic [16:0] RT_ALIGN [6] = '{17'd8, 17'd1, 17'd1, 17'd2, 17'd2, 17'd1};
	localparam logic [16:0] RT_SIZE  [6] = '{17'd8, 17'd1, 17'd1, 17'd4, 17'd2, 17'd1};
	localparam logic [7:0]  WPA_OUI  [4] = '{8'h00, 8'h50, 8'hF2, 8'h01};

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_BEACON = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;

	localparam logic [1:0] SEC_OPEN = 2'd0;
	localparam logic [1:0] SEC_WPA2 = 2'd1;
	localparam logic [1:0] SEC_WPA  = 2'd2;
	localparam logic [1:0] SEC_WEP  = 2'd3;

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_EXT  = 3'd1,
		PH_FLD  = 3'd2,
		PH_MAC  = 3'd3,
		PH_FIX  = 3'd4,
		PH_TID  = 3'd5,
		PH_TLEN = 3'd6,
		PH_TDAT = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [47:0]       bssid;
		logic [7:0]        chan;
		logic              rssi_valid;
		logic signed [7:0] rssi;
		logic [1:0]        sec;
	} res_t;

	typedef struct packed {
		logic [15:0] pos;
		phase_t      phase;
		logic [15:0] rt_len;
		logic [31:0] present;
		logic [2:0]  cursor;
		logic [15:0] fstart;
		logic [15:0] freq;
		logic [7:0]  rt_chan;
		logic [7:0]  sig;
		logic        sig_seen;
		logic [15:0] fctrl;
		logic [47:0] a1;
		logic [47:0] a2;
		logic [47:0] a3;
		logic        priv;
		logic [7:0]  tag_id;
		logic [7:0]  tag_left;
		logic [11:0] pend;
		logic [2:0]  bflags;
		logic        rej;
	} pst_t;

	typedef struct packed {
		logic        rej;
		logic [2:0]  cursor;
		logic [15:0] start;
	} nf_t;

	// x/5 by reciprocal, exact for x below 1024
	function automatic logic [7:0] freq_to_chan(logic [15:0] f);
		logic [9:0]  x;
		logic [17:0] m;
		x = '0;
		m = '0;
		if (f == 16'd2484) return 8'd14;
		if (f >= 16'd2412 && f <= 16'd2472) x = 10'(f - 16'd2407);
		else if (f >= 16'd5000 && f <= 16'd5900) x = 10'(f - 16'd5000);
		else return 8'd0;
		m = 18'(x) * 18'd205;
		return m[17:10];
	endfunction

endpackage

@@ rtl/whp_parse.sv @@
// ---------------------------------------------------------------------------
// Frame header parser core
// Per-byte state update and result build for one captured byte.
// ---------------------------------------------------------------------------
`include "wifi_frame_header_parser_top_defines.svh"

module whp_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  whp_pkg::item_t item,
	output logic           res_vld,
	output whp_pkg::res_t  res
);
	import whp_pkg::*;

	pst_t st_q;
	pst_t nx;

	// next present radiotap field from index c, offset o
	function automatic nf_t next_field(logic [2:0] c, logic [16:0] o, logic [31:0] pres,
			logic [15:0] len);
		nf_t         r;
		logic        found;
		logic [16:0] s;
		logic [17:0] e;
		r.rej    = 1'b0;
		r.cursor = NO_FIELD;
		r.start  = '0;
		found    = 1'b0;
		s        = '0;
		e        = '0;
		for (int f = 0; f < 6; f++) begin
			if (!found && f >= int'(c) && pres[f]) begin
				found = 1'b1;
				s = (o + RT_ALIGN[f] - 17'd1) & ~(RT_ALIGN[f] - 17'd1);
				e = {1'b0, s} + {1'b0, RT_SIZE[f]};
				if (e > {2'b0, len}) begin
					r.rej = 1'b1;
				end else begin
					r.start  = s[15:0];
					r.cursor = 3'(f);
				end
			end
		end
		return r;
	endfunction

	logic [15:0] p, d, idx;
	logic [7:0]  b;
	logic        mac_go, fin_go, nf_go, ok;
	logic [2:0]  nf_c, cnt;
	logic [16:0] nf_o, ofs;
	logic [31:0] pres_full;
	nf_t         nf;

	always_comb begin
		nx        = st_q;
		p         = st_q.pos;
		b         = item.data;
		d         = st_q.pos - st_q.rt_len;
		idx       = st_q.pos - st_q.fstart;
		mac_go    = 1'b0;
		fin_go    = 1'b0;
		nf_go     = 1'b0;
		nf_c      = '0;
		nf_o      = '0;
		ofs       = {1'b0, st_q.fstart} + 17'd4;
		pres_full = {b, st_q.present[23:0]};
		cnt       = st_q.pend[10:8];
		nf        = '0;
		ok        = 1'b0;
		res       = '0;
		if (go && st_q.pos != MAX_FRAME_BYTES) begin
			nx.pos = p + 16'd1;
			if (!st_q.rej) begin
				unique case (st_q.phase)
					PH_HDR: begin
						if (p == 16'd0) begin
							if (b != 8'd0) nx.rej = 1'b1;
						end else if (p == 16'd2) begin
							nx.rt_len = {8'd0, b};
						end else if (p == 16'd3) begin
							nx.rt_len = {b, st_q.rt_len[7:0]};
							if (nx.rt_len < 16'd8) nx.rej = 1'b1;
						end else if (p == 16'd4) begin
							nx.present[7:0] = b;
						end else if (p == 16'd5) begin
							nx.present[15:8] = b;
						end else if (p == 16'd6) begin
							nx.present[23:16] = b;
						end else if (p == 16'd7) begin
							nx.present = pres_full;
							if ((pres_full & EXT_BIT) != '0) begin
								if (st_q.rt_len < 16'd12) nx.rej = 1'b1;
								else begin
									nx.fstart = 16'd8;
									nx.phase  = PH_EXT;
								end
							end else begin
								nx.phase = PH_FLD;
								nf_go    = 1'b1;
								nf_o     = 17'd8;
							end
						end
					end
					PH_EXT: begin
						if ({1'b0, p} == {1'b0, st_q.fstart} + 17'd3) begin
							if (b[7]) begin
								if (ofs + 17'd4 > {1'b0, st_q.rt_len}) nx.rej = 1'b1;
								else nx.fstart = ofs[15:0];
							end else begin
								nx.phase = PH_FLD;
								nf_go    = 1'b1;
								nf_o     = ofs;
							end
						end
					end
					PH_FLD: begin
						if (p >= st_q.rt_len) begin
							nx.phase = PH_MAC;
							mac_go   = 1'b1;
						end else if (st_q.cursor != NO_FIELD && p >= st_q.fstart) begin
							if (st_q.cursor == 3'd3) begin
								if (idx == 16'd0) nx.freq = {8'd0, b};
								else if (idx == 16'd1) begin
									nx.freq    = {b, st_q.freq[7:0]};
									nx.rt_chan = freq_to_chan({b, st_q.freq[7:0]});
								end
							end else if (st_q.cursor == 3'd5) begin
								nx.sig      = b;
								nx.sig_seen = 1'b1;
							end
							if ({1'b0, idx} == RT_SIZE[st_q.cursor] - 17'd1) begin
								nf_go = 1'b1;
								nf_c  = st_q.cursor + 3'd1;
								nf_o  = {1'b0, st_q.fstart} + RT_SIZE[st_q.cursor];
							end
						end
					end
					PH_MAC: mac_go = 1'b1;
					PH_FIX: begin
						if (d == 16'd34) nx.priv = b[4];
						else if (d == 16'd35) nx.phase = PH_TID;
					end
					PH_TID: begin
						nx.tag_id = b;
						nx.pend   = '0;
						nx.phase  = PH_TLEN;
					end
					PH_TLEN: begin
						nx.tag_left = b;
						nx.pend     = st_q.pend;
						if (b == 8'd0) fin_go = 1'b1;
						else nx.phase = PH_TDAT;
					end
					PH_TDAT: begin
						if (cnt == 3'd0) nx.pend[7:0] = b;
						if (cnt < 3'd4) begin
							if (b != WPA_OUI[cnt[1:0]]) nx.pend[11] = 1'b1;
							nx.pend[10:8] = cnt + 3'd1;
						end
						nx.tag_left = st_q.tag_left - 8'd1;
						if (nx.tag_left == 8'd0) fin_go = 1'b1;
					end
				endcase
			end
		end
		if (mac_go) begin
			if (d == 16'd0) nx.fctrl = {8'd0, b};
			else if (d == 16'd1) nx.fctrl[15:8] = b;
			else if (d >= 16'd4 && d <= 16'd9) nx.a1 = {st_q.a1[39:0], b};
			else if (d >= 16'd10 && d <= 16'd15) nx.a2 = {st_q.a2[39:0], b};
			else if (d >= 16'd16 && d <= 16'd21) nx.a3 = {st_q.a3[39:0], b};
			else if (d == 16'd23) begin
				if (st_q.fctrl[3:2] == 2'd0 && st_q.fctrl[7:4] == 4'd8) nx.phase = PH_FIX;
			end
		end
		if (fin_go) begin
			if (nx.tag_id == TAG_DS && nx.pend[10:8] >= 3'd1) nx.rt_chan = nx.pend[7:0];
			else if (nx.tag_id == TAG_RSN) nx.bflags[0] = 1'b1;
			else if (nx.tag_id == TAG_VENDOR && nx.pend[10:8] == 3'd4 && !nx.pend[11])
				nx.bflags[1] = 1'b1;
			nx.phase = PH_TID;
		end
		if (nf_go) begin
			nf = next_field(nf_c, nf_o, nx.present, nx.rt_len);
			if (nf.rej) nx.rej = 1'b1;
			nx.cursor = nf.cursor;
			if (!nf.rej && nf.cursor != NO_FIELD) nx.fstart = nf.start;
		end

		// result from the state after this byte
		ok = !nx.rej && nx.phase >= PH_MAC && {1'b0, nx.pos} >= {1'b0, nx.rt_len} + 17'd24;
		if (ok) begin
			if (nx.phase >= PH_TID) begin
				res.kind  = KIND_BEACON;
				res.bssid = nx.a3;
				if (!nx.priv) res.sec = SEC_OPEN;
				else if (nx.bflags[0]) res.sec = SEC_WPA2;
				else if (nx.bflags[1]) res.sec = SEC_WPA;
				else res.sec = SEC_WEP;
			end else if (nx.phase == PH_MAC && nx.fctrl[3:2] == 2'd2) begin
				unique case (nx.fctrl[9:8])
					2'b00: begin res.kind = KIND_DATA; res.bssid = nx.a3; end
					2'b01: begin res.kind = KIND_DATA; res.bssid = nx.a1; end
					2'b10: begin res.kind = KIND_DATA; res.bssid = nx.a2; end
					2'b11: res.kind = KIND_NONE;
				endcase
			end
		end
		if (res.kind != KIND_NONE) begin
			res.chan       = nx.rt_chan;
			res.rssi_valid = nx.sig_seen;
			res.rssi       = nx.sig_seen ? nx.sig : 8'sd0;
		end
		res_vld = go && item.last;
		if (res_vld) nx = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= nx;
		end
	end

	`WHP_ASSERT_NEXT(a_clear_after_frame, clk, arst_n, res_vld,
		st_q.pos == 16'd0 && st_q.phase == PH_HDR, "state not cleared after frame")
	`WHP_ASSERT_IMPL(a_reject_zero, clk, arst_n, res_vld && res.kind == KIND_NONE,
		res.bssid == 48'd0 && res.chan == 8'd0 && !res.rssi_valid, "rejected frame not zeroed")
	`WHP_ASSERT_IMPL(a_data_open, clk, arst_n, res_vld && res.kind == KIND_DATA,
		res.sec == SEC_OPEN, "data frame reports security")

endmodule

@@ rtl/whp_out_reg.sv @@
// ---------------------------------------------------------------------------
// Frame header parser result register
// Holds one result until the downstream side takes the transaction.
// ---------------------------------------------------------------------------
module whp_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_vld,
	input  whp_pkg::res_t res,
	input  logic          m_tready,
	output logic          m_tvalid,
	output whp_pkg::res_t res_q,
	output logic          free
);
	import whp_pkg::*;

	logic vld_q;

	assign m_tvalid = vld_q;
	assign free     = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_vld) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			res_q <= res;
		end
	end

endmodule

@@ rtl/wifi_frame_header_parser_top.sv @@
// ---------------------------------------------------------------------------
// Radiotap / 802.11 frame header parser
// Byte stream in, one summary transaction out per captured frame.
// ---------------------------------------------------------------------------
// Takes one captured byte per cycle, radiotap header first, s_tlast on the
// final byte of the frame. Each byte passes an input register, then the
// per-byte parse step updates the frame state in the same cycle; the result
// for a frame is registered in the result register as its last byte
// leaves the input register. Input stalls only when a frame's last byte
// meets a result register still holding an untaken transaction.
`include "wifi_frame_header_parser_top_defines.svh"

module wifi_frame_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [47:0] bssid, [55:48] channel_number,
	                               // [56] rssi_valid, [64:57] rssi_dbm, [66:65] security
	output logic [1:0]  m_tuser    // [1:0] frame_kind
);
	import whp_pkg::*;

	item_t item_s1;
	logic  vld_s1;
	logic  consume, out_free, res_vld;
	res_t  res, res_q;

	assign consume  = vld_s1 && (!item_s1.last || out_free);
	assign s_tready = !vld_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{data: s_tdata, last: s_tlast};
		end
	end

	whp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (consume),
		.item    (item_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	whp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_vld  (res_vld),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res_q    (res_q),
		.free     (out_free)
	);

	assign m_tuser = res_q.kind;
	assign m_tdata = {5'd0, res_q.sec, res_q.rssi, res_q.rssi_valid, res_q.chan, res_q.bssid};

	`WHP_ASSERT_NEXT(a_last_gives_result, clk, arst_n, consume && item_s1.last,
		m_tvalid, "frame end without result")
	`WHP_ASSERT_IMPL(a_no_overwrite, clk, arst_n, m_tvalid && !m_tready,
		!(consume && item_s1.last), "pending result overwritten")
	`WHP_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !vld_s1, s_tready,
		"input blocked while stage empty")

endmodule

@@ dv/tb_wifi_frame_header_parser_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Frame header parser testbench
// Feeds captured radiotap / 802.11 frames byte by byte, with random gaps and
// receiver stalls. A byte-level parser model predicts each frame summary, and
// the testbench compares every summary transaction field by field.
// ---------------------------------------------------------------------------
module tb_wifi_frame_header_parser_top;
	import whp_pkg::*;

	localparam int unsigned FLD_NONE  = 6;
	localparam int unsigned FRAME_CAP = 65535;

	// frame classes for the generator
	localparam int GEN_BEACON = 0;
	localparam int GEN_DATA   = 1;
	localparam int GEN_OTHER  = 2;
	localparam int GEN_NOISE  = 3;

	// beacon security choices
	localparam int BSEC_RAND = -1;
	localparam int BSEC_OPEN = 0;
	localparam int BSEC_WEP  = 1;
	localparam int BSEC_WPA2 = 2;
	localparam int BSEC_WPA  = 3;

	localparam int DS_RAND = -1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	wifi_frame_header_parser_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// ---------------- frame parser model ----------------
	int unsigned fld_align [6] = '{8, 1, 1, 2, 2, 1};
	int unsigned fld_size  [6] = '{8, 1, 1, 4, 2, 1};
	logic [7:0]  wpa_magic [4] = '{8'h00, 8'h50, 8'hF2, 8'h01};

	int unsigned pos, rlen, fcur, fst, freq, rch, sig, fctl, tid, tleft, pend, bfl;
	logic [31:0] pres;
	logic [47:0] adr1, adr2, adr3;
	logic        sseen, priv, rej;
	phase_t      ph;

	res_t summary_q [$];
	res_t typed_summary;
	bit   use_typed;
	int   err_cnt;
	int   bytes_sent;
	int   frames_sent;

	function automatic int unsigned chan_of_freq(int unsigned f);
		if (f == 2484) return 14;
		if (f >= 2412 && f <= 2472) return (f - 2407) / 5;
		if (f >= 5000 && f <= 5900) return (f - 5000) / 5;
		return 0;
	endfunction

	task automatic clear_parser();
		pos = 0; ph = PH_HDR; rlen = 0; pres = '0; fcur = 0; fst = 0; freq = 0;
		rch = 0; sig = 0; sseen = 0; fctl = 0; adr1 = '0; adr2 = '0; adr3 = '0;
		priv = 0; tid = 0; tleft = 0; pend = 0; bfl = 0; rej = 0;
	endtask

	task automatic seek_field(int unsigned c, int unsigned o);
		int unsigned s;
		for (int unsigned f = c; f < 6; f++) begin
			if (pres[f]) begin
				s = (o + fld_align[f] - 1) & ~(fld_align[f] - 1);
				if (s + fld_size[f] > rlen) begin
					rej = 1;
					fcur = FLD_NONE;
					return;
				end
				fst = s;
				fcur = f;
				return;
			end
		end
		fcur = FLD_NONE;
	endtask

	task automatic close_tag();
		int unsigned cnt;
		cnt = (pend >> 8) & 7;
		if (tid == TAG_DS && cnt >= 1) rch = pend & 8'hFF;
		else if (tid == TAG_RSN) bfl |= 1;
		else if (tid == TAG_VENDOR && cnt == 4 && ((pend >> 11) & 1) == 0) bfl |= 2;
		ph = PH_TID;
	endtask

	task automatic parse_byte(int unsigned b);
		int unsigned p, d, idx, o, cnt;
		p = pos;
		if (rej) return;
		case (ph)
			PH_HDR: begin
				if (p == 0 && b != 0) rej = 1;
				else if (p == 2) rlen = b;
				else if (p == 3) begin
					rlen |= b << 8;
					if (rlen < 8) rej = 1;
				end else if (p >= 4 && p <= 7) begin
					pres |= 32'(b) << (8 * (p - 4));
					if (p == 7) begin
						if (pres[31]) begin
							if (rlen < 12) rej = 1;
							else begin
								fst = 8;
								ph = PH_EXT;
							end
						end else begin
							ph = PH_FLD;
							seek_field(0, 8);
						end
					end
				end
				return;
			end
			PH_EXT: begin
				if (p == fst + 3) begin
					o = fst + 4;
					if (b & 8'h80) begin
						if (o + 4 > rlen) rej = 1;
						else fst = o;
					end else begin
						ph = PH_FLD;
						seek_field(0, o);
					end
				end
				return;
			end
			PH_FLD: begin
				if (p >= rlen) ph = PH_MAC;
				else begin
					if (fcur < FLD_NONE && p >= fst) begin
						idx = p - fst;
						if (fcur == 3) begin
							if (idx == 0) freq = b;
							else if (idx == 1) begin
								freq |= b << 8;
								rch = chan_of_freq(freq);
							end
						end else if (fcur == 5) begin
							sig = b;
							sseen = 1;
						end
						if (idx == fld_size[fcur] - 1)
							seek_field(fcur + 1, fst + fld_size[fcur]);
					end
					return;
				end
			end
			default: ;
		endcase
		d = p - rlen;
		case (ph)
			PH_MAC: begin
				if (d == 0) fctl = b;
				else if (d == 1) fctl |= b << 8;
				else if (d >= 4 && d <= 9) adr1 = {adr1[39:0], b[7:0]};
				else if (d >= 10 && d <= 15) adr2 = {adr2[39:0], b[7:0]};
				else if (d >= 16 && d <= 21) adr3 = {adr3[39:0], b[7:0]};
				else if (d == 23) begin
					if (((fctl >> 2) & 3) == 0 && ((fctl >> 4) & 15) == 8) ph = PH_FIX;
				end
			end
			PH_FIX: begin
				if (d == 34) priv = (b & 8'h10) != 0;
				else if (d == 35) ph = PH_TID;
			end
			PH_TID: begin
				tid = b;
				pend = 0;
				ph = PH_TLEN;
			end
			PH_TLEN: begin
				tleft = b;
				if (b == 0) close_tag();
				else ph = PH_TDAT;
			end
			default: begin
				cnt = (pend >> 8) & 7;
				if (cnt == 0) pend = (pend & ~32'hFF) | b;
				if (cnt < 4) begin
					if (b != wpa_magic[cnt]) pend |= 32'h800;
					pend = (pend & ~32'h700) | ((cnt + 1) << 8);
				end
				tleft = (tleft - 1) & 8'hFF;
				if (tleft == 0) close_tag();
			end
		endcase
	endtask

	// frame summary on the last byte; the model state returns to reset
	task automatic summarise(output res_t r);
		r = '0;
		if (!rej && ph >= PH_MAC && pos >= rlen + 24) begin
			if (ph >= PH_TID) begin
				r.kind  = KIND_BEACON;
				r.bssid = adr3;
				if (!priv) r.sec = SEC_OPEN;
				else if (bfl & 1) r.sec = SEC_WPA2;
				else if (bfl & 2) r.sec = SEC_WPA;
				else r.sec = SEC_WEP;
			end else if (ph == PH_MAC && ((fctl >> 2) & 3) == 2) begin
				case (fctl & 32'h300)
					32'h000: begin r.kind = KIND_DATA; r.bssid = adr3; end
					32'h100: begin r.kind = KIND_DATA; r.bssid = adr1; end
					32'h200: begin r.kind = KIND_DATA; r.bssid = adr2; end
					default: ;
				endcase
			end
		end
		if (r.kind != KIND_NONE) begin
			r.chan       = rch[7:0];
			r.rssi_valid = sseen;
			r.rssi       = sseen ? sig[7:0] : 8'd0;
		end
		clear_parser();
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk) begin : monitor
		res_t r;
		res_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (pos < FRAME_CAP) begin
					parse_byte(s_tdata);
					pos++;
				end
				if (s_tlast) begin
					summarise(r);
					summary_q.push_back(use_typed ? typed_summary : r);
				end
			end
			if (m_tvalid && m_tready) begin
				if (summary_q.size() == 0) report("unexpected transaction", m_tuser, 0);
				else begin
					want = summary_q.pop_front();
					if (m_tuser != want.kind) report("frame_kind", m_tuser, want.kind);
					if (m_tdata[47:0] != want.bssid) report("bssid", m_tdata[47:0], want.bssid);
					if (m_tdata[55:48] != want.chan) report("channel", m_tdata[55:48], want.chan);
					if (m_tdata[56] != want.rssi_valid)
						report("rssi_valid", m_tdata[56], want.rssi_valid);
					if (m_tdata[64:57] != want.rssi) report("rssi_dbm", m_tdata[64:57], want.rssi);
					if (m_tdata[66:65] != want.sec) report("security", m_tdata[66:65], want.sec);
				end
			end
		end
	end

	// ---------------- receiver ----------------
	int  hold_left;
	bit  hold_go;
	bit  rx_busy_mode;

	initial begin
		m_tready = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else if ($urandom_range(0, 299) == 0) begin
				hold_left = $urandom_range(10, 60);
				m_tready <= 0;
			end else if ($urandom_range(0, 99) == 0) begin
				rx_busy_mode = !rx_busy_mode;
				m_tready <= 1;
			end else
				m_tready <= rx_busy_mode ? 1'b1 : ($urandom_range(0, 9) < 6);
		end
	end

	// ---------------- sender ----------------
	logic [7:0] frame_bytes [$];
	bit         no_gaps;

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic put_byte(logic [7:0] b, logic l, int gap);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 0;
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_frame();
		no_gaps = ($urandom_range(0, 3) == 0);
		foreach (frame_bytes[i])
			put_byte(frame_bytes[i], i == frame_bytes.size() - 1, pick_gap());
		frames_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 0;
		while (summary_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_tag(logic [7:0] id, int len, logic [7:0] first, bit oui_ok);
		frame_bytes.push_back(id);
		frame_bytes.push_back(len[7:0]);
		for (int i = 0; i < len; i++) begin
			if (i == 0) frame_bytes.push_back(oui_ok && id == TAG_VENDOR ? wpa_magic[0] : first);
			else if (id == TAG_VENDOR && oui_ok && i < 4) frame_bytes.push_back(wpa_magic[i]);
			else frame_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic build_frame(int cls, int ds_sel, int bsec, bit cut);
		logic [7:0]  rt [64];
		logic [31:0] pw;
		int          n_ext, off, rl, fpos, f, bs, n, body;
		int unsigned fr;
		frame_bytes.delete();
		if (cls == GEN_NOISE) begin
			n = $urandom_range(1, 40);
			repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1)) frame_bytes[0] = 8'h00;
			return;
		end
		foreach (rt[i]) rt[i] = 8'($urandom_range(0, 255));
		n_ext = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
		pw = {1'b0, ($urandom_range(0, 3) == 0) ? 25'($urandom) : 25'd0, 6'($urandom)};
		if (n_ext > 0) pw[31] = 1;
		off = 8 + 4 * n_ext;
		for (int e = 0; e < n_ext; e++) rt[11 + 4 * e][7] = (e != n_ext - 1);
		for (f = 0; f < 6; f++) begin
			if (pw[f]) begin
				off = (off + fld_align[f] - 1) & ~(fld_align[f] - 1);
				fpos = off;
				if (f == 3) begin
					case ($urandom_range(0, 4))
						0: fr = 2412 + 5 * $urandom_range(0, 12);
						1: fr = 2484;
						2: fr = 5000 + 5 * $urandom_range(0, 180);
						3: fr = $urandom_range(2400, 2490);
						default: fr = $urandom_range(0, 65535);
					endcase
					rt[fpos] = fr[7:0];
					rt[fpos + 1] = fr[15:8];
				end
				off += fld_size[f];
			end
		end
		rl = off + $urandom_range(0, 3);
		if ($urandom_range(0, 12) == 0) rl = $urandom_range(0, off);
		rt[0] = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		rt[2] = rl[7:0];
		rt[3] = rl[15:8];
		{rt[7], rt[6], rt[5], rt[4]} = pw;
		for (int i = 0; i < rl; i++) frame_bytes.push_back(rt[i]);
		// 802.11 header
		case (cls)
			GEN_BEACON: frame_bytes.push_back(8'h80);
			GEN_DATA:   frame_bytes.push_back({4'($urandom), 4'b1000});
			default:    frame_bytes.push_back($urandom_range(0, 1) ? 8'h40 : 8'($urandom));
		endcase
		frame_bytes.push_back({6'($urandom), ds_sel < 0 ? 2'($urandom) : 2'(ds_sel)});
		repeat (22) frame_bytes.push_back(8'($urandom_range(0, 255)));
		if (cls == GEN_BEACON) begin
			bs = (bsec == BSEC_RAND) ? $urandom_range(0, 3) : bsec;
			repeat (12) frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes[rl + 34][4] = (bs != BSEC_OPEN) ? 1'b1 : ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) add_tag(8'd0, $urandom_range(0, 8), 8'($urandom), 0);
			if ($urandom_range(0, 2) != 0)
				add_tag(TAG_DS, $urandom_range(0, 2), 8'($urandom_range(0, 255)), 0);
			if (bs == BSEC_WPA2 || (bsec == BSEC_RAND && $urandom_range(0, 3) == 0))
				add_tag(TAG_RSN, $urandom_range(0, 20), 8'($urandom), 0);
			if (bs == BSEC_WPA || (bsec == BSEC_RAND && $urandom_range(0, 3) == 0))
				add_tag(TAG_VENDOR, $urandom_range(3, 9), 8'($urandom), $urandom_range(0, 4) != 0);
			if ($urandom_range(0, 2) == 0)
				add_tag(8'($urandom), $urandom_range(0, 6), 8'($urandom), 0);
			// truncated trailing tag
			if ($urandom_range(0, 3) == 0) begin
				add_tag(($urandom_range(0, 1)) ? TAG_DS : TAG_VENDOR, 5, 8'($urandom), 1);
				repeat ($urandom_range(1, 6)) void'(frame_bytes.pop_back());
			end
		end else begin
			body = $urandom_range(0, 16);
			repeat (body) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (cut) begin
			n = $urandom_range(1, frame_bytes.size());
			while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
		end
	endtask

	// ---------------- directed table ----------------
	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		res_t       r;
	} row_t;

	row_t dir_rows [19];

	initial begin
		int cls;
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		use_typed = 0;
		typed_summary = '0;
		err_cnt = 0;
		bytes_sent = 0;
		frames_sent = 0;
		hold_go = 0;
		rx_busy_mode = 0;
		no_gaps = 0;
		clear_parser();
		dir_rows = '{
			// one-byte frames
			'{8'h00, 1'b1, 1'b1, '0}, '{8'h01, 1'b1, 1'b1, '0}, '{8'hFF, 1'b1, 1'b1, '0},
			// radiotap length below 8
			'{8'h00, 1'b0, 1'b1, '0}, '{8'h00, 1'b0, 1'b1, '0}, '{8'h04, 1'b0, 1'b1, '0},
			'{8'h00, 1'b1, 1'b1, '0},
			// maximum length, frame ends in the header
			'{8'h00, 1'b0, 1'b1, '0}, '{8'hAA, 1'b0, 1'b1, '0}, '{8'hFF, 1'b0, 1'b1, '0},
			'{8'hFF, 1'b1, 1'b1, '0},
			// extended bitmap does not fit an 8-byte header
			'{8'h00, 1'b0, 1'b1, '0}, '{8'h7F, 1'b0, 1'b1, '0}, '{8'h08, 1'b0, 1'b1, '0},
			'{8'h00, 1'b0, 1'b1, '0}, '{8'hFF, 1'b0, 1'b1, '0}, '{8'hFF, 1'b0, 1'b1, '0},
			'{8'hFF, 1'b0, 1'b1, '0}, '{8'hFF, 1'b1, 1'b1, '0}
		};
		repeat (7) @(negedge clk);
		arst_n = 1;

		use_typed = 1;
		foreach (dir_rows[i]) begin
			typed_summary = dir_rows[i].r;
			put_byte(dir_rows[i].b, dir_rows[i].l, $urandom_range(0, 2));
		end
		wait_drained();
		use_typed = 0;

		// beacon, data and other frame classes, every DS combination and security class once
		build_frame(GEN_BEACON, DS_RAND, BSEC_OPEN, 0); send_frame();
		build_frame(GEN_BEACON, DS_RAND, BSEC_WEP, 0);  send_frame();
		build_frame(GEN_BEACON, DS_RAND, BSEC_WPA2, 0); send_frame();
		build_frame(GEN_BEACON, DS_RAND, BSEC_WPA, 0);  send_frame();
		for (int ds = 0; ds < 4; ds++) begin
			build_frame(GEN_DATA, ds, BSEC_RAND, 0);
			send_frame();
		end
		build_frame(GEN_OTHER, DS_RAND, BSEC_RAND, 0); send_frame();
		build_frame(GEN_BEACON, DS_RAND, BSEC_RAND, 1); send_frame();
		wait_drained();

		// long receiver hold while frames keep coming
		hold_go = 1;
		repeat (8) begin
			build_frame(GEN_BEACON + $urandom_range(0, 1), DS_RAND, BSEC_RAND, 0);
			send_frame();
		end

		while (bytes_sent < 1200) begin
			cls = $urandom_range(0, 99);
			cls = (cls < 45) ? GEN_BEACON : (cls < 80) ? GEN_DATA : (cls < 90) ? GEN_OTHER
				: GEN_NOISE;
			build_frame(cls, DS_RAND, BSEC_RAND, $urandom_range(0, 9) == 0);
			send_frame();
			if ($urandom_range(0, 29) == 0) wait_drained();
		end

		@(negedge clk);
		s_tvalid <= 0;
		while (summary_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/whp_pkg.sv
rtl/whp_parse.sv
rtl/whp_out_reg.sv
rtl/wifi_frame_header_parser_top.sv
dv/tb_wifi_frame_header_parser_top.sv
